[design/planar_three_link_forward_kinematics_defines.svh]
`ifndef PLANAR_THREE_LINK_FORWARD_KINEMATICS_DEFINES_SVH
`define PLANAR_THREE_LINK_FORWARD_KINEMATICS_DEFINES_SVH

// property checked on clk while the block is out of reset
`define PL3FK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on clk at every edge, reset included
`define PL3FK_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pl3fk_pkg.sv]
`timescale 1ns / 1ps

package pl3fk_pkg;

	// cordic depth and table size
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int LANES         = 3;

	// widths
	localparam int ANG_W  = 16;
	localparam int LEN_W  = 16;
	localparam int OUT_W  = 19;
	localparam int CW     = 33;
	localparam int ZW     = 32;
	localparam int MAG_W  = 31;
	localparam int PROD_W = LEN_W + MAG_W;
	localparam int TERM_W = 17;

	// pipeline: prep, cordic chain, clamp, multiply, round, sum
	localparam int NUM_ST = CORDIC_STAGES + 5;

	typedef logic signed [CW-1:0] cord_t;
	typedef logic signed [ZW-1:0] phase_t;
	typedef logic [ANG_W-1:0]     ang_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [MAG_W-1:0]     mag_t;
	typedef logic [PROD_W-1:0]    prod_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [OUT_W-1:0]  coord_t;

	// register indexes
	typedef enum logic [1:0] {
		REG_LINK_ONE   = 2'd0,
		REG_LINK_TWO   = 2'd1,
		REG_LINK_THREE = 2'd2
	} reg_idx_t;

	localparam cord_t GAIN_Q30 = 33'sd652032874;
	localparam cord_t UNIT_Q30 = 33'sd1073741824;
	localparam logic signed [ANG_W-1:0] QTR_ANG = 16'sd16384;
	localparam ang_t  HALF_ANG = 16'h8000;
	localparam prod_t ROUND_HALF = PROD_W'(64'd536870912);

	// atan(2^-i) in units of 2^-32 turn
	function automatic phase_t atan_entry(input int i);
		case (i)
			0:  return 32'sd536870912;
			1:  return 32'sd316933406;
			2:  return 32'sd167458907;
			3:  return 32'sd85004756;
			4:  return 32'sd42667331;
			5:  return 32'sd21419969;
			6:  return 32'sd10679838;
			7:  return 32'sd5340245;
			8:  return 32'sd2670163;
			9:  return 32'sd1335087;
			10: return 32'sd667544;
			11: return 32'sd333772;
			12: return 32'sd166886;
			13: return 32'sd83443;
			14: return 32'sd41722;
			15: return 32'sd20861;
			16: return 32'sd10430;
			17: return 32'sd5215;
			18: return 32'sd2608;
			19: return 32'sd1304;
			20: return 32'sd652;
			21: return 32'sd326;
			22: return 32'sd163;
			23: return 32'sd81;
			default: return '0;
		endcase
	endfunction

endpackage

[design/planar_three_link_forward_kinematics.sv]
`timescale 1ns / 1ps
// Forward kinematics of a planar three-link arm.
// Configuration: cfg_we writes cfg_data into the link length picked by
// cfg_index (0 first, 1 second, 2 third link, unsigned Q4.12); index 3 is
// ignored. Write lengths only while no word is in flight.
// Input channel (in_valid/in_ready) takes three joint angles as binary angles
// (65536 per turn); output channel (out_valid/out_ready) gives end_x and
// end_z, signed Q6.12, one result word per input word, in order.
// Each angle sum goes through its own pipelined rotation-mode cordic, one
// iteration per stage, then clamp, multiply by link length, round and sum.
// Throughput: one word per cycle while out_ready is high; the pipeline depth of
// CORDIC_STAGES + 5 stages sets the latency, not the rate.
// Stall: every stage holds while the stage after it is full and stalled, so
// a stalled receiver fills the pipeline bubbles first; in_ready drops only
// once every stage holds a word. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits and the link lengths to zero.
module planar_three_link_forward_kinematics import pl3fk_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [$bits(reg_idx_t)-1:0] cfg_index,
	input  logic [LEN_W-1:0]            cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ANG_W-1:0]            shoulder_angle,
	input  logic [ANG_W-1:0]            elbow_angle,
	input  logic [ANG_W-1:0]            wrist_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [OUT_W-1:0]     end_x,
	output logic signed [OUT_W-1:0]     end_z
);

	localparam int ST_CLAMP = CORDIC_STAGES + 1;
	localparam int ST_MUL   = CORDIC_STAGES + 2;
	localparam int ST_RND   = CORDIC_STAGES + 3;
	localparam int ST_SUM   = CORDIC_STAGES + 4;

	len_t len_q [LANES];

	logic [NUM_ST-1:0] vld_q;
	logic [NUM_ST:0]   en;

	// link length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				len_q[l] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINK_ONE:   len_q[0] <= cfg_data;
				REG_LINK_TWO:   len_q[1] <= cfg_data;
				REG_LINK_THREE: len_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its word moves on
	assign en[NUM_ST] = out_ready;
	for (genvar k = 0; k < NUM_ST; k++) begin : g_en
		assign en[k] = ~vld_q[k] | en[k+1];
	end
	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_ST-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_ST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: cumulative angles, fold into +-quarter turn
	ang_t   ang [LANES];
	phase_t z_s1 [LANES];
	logic   flip_s1 [LANES];
	logic   flip_n [LANES];
	ang_t   ang_n [LANES];

	always_comb begin
		ang[0] = shoulder_angle;
		ang[1] = shoulder_angle + elbow_angle;
		ang[2] = shoulder_angle + elbow_angle + wrist_angle;
		for (int l = 0; l < LANES; l++) begin
			flip_n[l] = ($signed(ang[l]) > QTR_ANG) || ($signed(ang[l]) < -QTR_ANG);
			ang_n[l]  = flip_n[l] ? (ang[l] ^ HALF_ANG) : ang[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < LANES; l++) begin
				z_s1[l]    <= phase_t'({ang_n[l], 16'h0000});
				flip_s1[l] <= flip_n[l];
			end
		end
	end

	// stage 2: cordic chain, one iteration per register stage
	cord_t  x_s2 [CORDIC_STAGES][LANES];
	cord_t  y_s2 [CORDIC_STAGES][LANES];
	phase_t z_s2 [CORDIC_STAGES][LANES];
	logic   flip_s2 [CORDIC_STAGES][LANES];
	cord_t  xin [CORDIC_STAGES][LANES];
	cord_t  yin [CORDIC_STAGES][LANES];
	phase_t zin [CORDIC_STAGES][LANES];
	logic   fin [CORDIC_STAGES][LANES];
	cord_t  xn [CORDIC_STAGES][LANES];
	cord_t  yn [CORDIC_STAGES][LANES];
	phase_t zn [CORDIC_STAGES][LANES];

	// stage inputs
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			xin[0][l] = GAIN_Q30;
			yin[0][l] = '0;
			zin[0][l] = z_s1[l];
			fin[0][l] = flip_s1[l];
		end
		for (int i = 1; i < CORDIC_STAGES; i++) begin
			for (int l = 0; l < LANES; l++) begin
				xin[i][l] = x_s2[i-1][l];
				yin[i][l] = y_s2[i-1][l];
				zin[i][l] = z_s2[i-1][l];
				fin[i][l] = flip_s2[i-1][l];
			end
		end
	end

	// micro-rotations
	always_comb begin
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			for (int l = 0; l < LANES; l++) begin
				if (!zin[i][l][ZW-1]) begin
					xn[i][l] = xin[i][l] - (yin[i][l] >>> i);
					yn[i][l] = yin[i][l] + (xin[i][l] >>> i);
					zn[i][l] = zin[i][l] - atan_entry(i);
				end else begin
					xn[i][l] = xin[i][l] + (yin[i][l] >>> i);
					yn[i][l] = yin[i][l] - (xin[i][l] >>> i);
					zn[i][l] = zin[i][l] + atan_entry(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (en[i+1]) begin
				for (int l = 0; l < LANES; l++) begin
					x_s2[i][l]    <= xn[i][l];
					y_s2[i][l]    <= yn[i][l];
					z_s2[i][l]    <= zn[i][l];
					flip_s2[i][l] <= fin[i][l];
				end
			end
		end
	end

	// stage 3: clamp to +-1, undo the fold, split sign and magnitude
	cord_t cc [LANES];
	cord_t sc [LANES];
	cord_t ca [LANES];
	cord_t sa [LANES];
	mag_t  cmag_s3 [LANES];
	mag_t  smag_s3 [LANES];
	logic  cneg_s3 [LANES];
	logic  sneg_s3 [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			cc[l] = x_s2[CORDIC_STAGES-1][l];
			sc[l] = y_s2[CORDIC_STAGES-1][l];
			if (cc[l] > UNIT_Q30) cc[l] = UNIT_Q30;
			if (cc[l] < -UNIT_Q30) cc[l] = -UNIT_Q30;
			if (sc[l] > UNIT_Q30) sc[l] = UNIT_Q30;
			if (sc[l] < -UNIT_Q30) sc[l] = -UNIT_Q30;
			if (flip_s2[CORDIC_STAGES-1][l]) begin
				cc[l] = -cc[l];
				sc[l] = -sc[l];
			end
			ca[l] = cc[l][CW-1] ? -cc[l] : cc[l];
			sa[l] = sc[l][CW-1] ? -sc[l] : sc[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_CLAMP]) begin
			for (int l = 0; l < LANES; l++) begin
				cmag_s3[l] <= ca[l][MAG_W-1:0];
				smag_s3[l] <= sa[l][MAG_W-1:0];
				cneg_s3[l] <= cc[l][CW-1];
				sneg_s3[l] <= sc[l][CW-1];
			end
		end
	end

	// stage 4: scale by link length
	prod_t cprod_s4 [LANES];
	prod_t sprod_s4 [LANES];
	logic  cneg_s4 [LANES];
	logic  sneg_s4 [LANES];

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			for (int l = 0; l < LANES; l++) begin
				cprod_s4[l] <= PROD_W'(len_q[l]) * PROD_W'(cmag_s3[l]);
				sprod_s4[l] <= PROD_W'(len_q[l]) * PROD_W'(smag_s3[l]);
				cneg_s4[l]  <= cneg_s3[l];
				sneg_s4[l]  <= sneg_s3[l];
			end
		end
	end

	// stage 5: round half away from zero, restore sign
	prod_t crnd [LANES];
	prod_t srnd [LANES];
	term_t cterm [LANES];
	term_t sterm [LANES];
	term_t cterm_s5 [LANES];
	term_t sterm_s5 [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			crnd[l]  = cprod_s4[l] + ROUND_HALF;
			srnd[l]  = sprod_s4[l] + ROUND_HALF;
			cterm[l] = $signed({1'b0, crnd[l][30+LEN_W-1:30]});
			sterm[l] = $signed({1'b0, srnd[l][30+LEN_W-1:30]});
			if (cneg_s4[l]) cterm[l] = -cterm[l];
			if (sneg_s4[l]) sterm[l] = -sterm[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_RND]) begin
			for (int l = 0; l < LANES; l++) begin
				cterm_s5[l] <= cterm[l];
				sterm_s5[l] <= sterm[l];
			end
		end
	end

	// stage 6: sum of the three link terms
	coord_t x_s6;
	coord_t z_s6;

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			x_s6 <= OUT_W'(cterm_s5[0]) + OUT_W'(cterm_s5[1]) + OUT_W'(cterm_s5[2]);
			z_s6 <= OUT_W'(sterm_s5[0]) + OUT_W'(sterm_s5[1]) + OUT_W'(sterm_s5[2]);
		end
	end

	assign end_x = x_s6;
	assign end_z = z_s6;

endmodule

[design/pl3fk_checker.sv]
`timescale 1ns / 1ps
`include "planar_three_link_forward_kinematics_defines.svh"

module pl3fk_checker import pl3fk_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic [$bits(reg_idx_t)-1:0] cfg_index,
	input logic [LEN_W-1:0]            cfg_data,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [ANG_W-1:0]            shoulder_angle,
	input logic [ANG_W-1:0]            elbow_angle,
	input logic [ANG_W-1:0]            wrist_angle,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [OUT_W-1:0]     end_x,
	input logic signed [OUT_W-1:0]     end_z
);

	// a stalled result word holds
	`PL3FK_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(end_x) && $stable(end_z)), "stalled result word changed")

	// an edge in reset leaves no result word behind
	`PL3FK_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !out_valid, "result word after reset edge")

	// a free output stage means the pipeline can take a word
	`PL3FK_ASSERT(a_ready_free, (!out_valid || out_ready) |-> in_ready, "in_ready low with free output")

	// three terms of at most 65535 each bound the end point
	`PL3FK_ASSERT(a_range, out_valid |-> (end_x <= 196605 && end_x >= -196605 && end_z <= 196605 && end_z >= -196605), "end point out of reach")

endmodule

bind planar_three_link_forward_kinematics pl3fk_checker u_pl3fk_checker (.*);
